### rtl/core/ptt_pkg.sv
// Package for the periodic timer table: codes, controller/datapath records.
// No dependencies; used by ptt_ctrl, ptt_datapath and periodic_timer_table.
package ptt_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_TICK    = 3'd4,
    CMD_SERVICE = 3'd5,
    CMD_QUERY   = 3'd6
  } cmd_e;

  localparam logic [2:0] KIND_DONE   = 3'd0;
  localparam logic [2:0] KIND_REJECT = 3'd1;
  localparam logic [2:0] KIND_WAKE   = 3'd2;
  localparam logic [2:0] KIND_DUE    = 3'd3;
  localparam logic [2:0] KIND_QUERY  = 3'd4;

  localparam int unsigned MAX_BODY = 16;
  localparam int unsigned BODY_W   = $clog2(MAX_BODY + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_MUL,
    S_START,
    S_TICK_RD,
    S_TICK_UPD,
    S_WAKE,
    S_SRV_RD,
    S_SRV_CHK,
    S_QRY_RD,
    S_QRY_EMIT,
    S_DONE_TID,
    S_DONE_IDX,
    S_CLOSE,
    S_REJECT
  } state_e;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_ALLOC,
    DP_CLEAR,
    DP_MUL,
    DP_START,
    DP_TICK_BEGIN,
    DP_TICK_UPD,
    DP_SRV_CLR
  } dp_op_e;

  typedef enum logic [2:0] {
    EM_REJECT,
    EM_DONE_TID,
    EM_DONE_IDX,
    EM_CLOSE,
    EM_WAKE,
    EM_DUE,
    EM_QUERY
  } emit_e;

  typedef struct packed {
    logic   latch;
    logic   idx_clr;
    logic   idx_inc;
    logic   n_inc;
    logic   addr_tid;
    dp_op_e op;
    logic   emit;
    emit_e  emit_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       tid_ok;
    logic       task_ok;
    logic       tid_in_use;
    logic       now_eq_prev;
    logic       idx_end_timer;
    logic       idx_last_timer;
    logic       idx_end_task;
    logic       free_at_idx;
    logic       srv_match;
    logic       pending_at_idx;
    logic       n_full;
    logic       out_free;
  } dp_status_t;

endpackage

### rtl/core/ptt_req_if.sv
// Request channel of the periodic timer table: valid/ready plus command fields.
// No dependencies.
interface ptt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  timer_id;
  logic [7:0]  task_id;
  logic [31:0] unit;
  logic [31:0] duration;
  logic [31:0] now_ticks;

  modport source (
    output valid, command, timer_id, task_id, unit, duration, now_ticks,
    input  ready
  );
  modport sink (
    input  valid, command, timer_id, task_id, unit, duration, now_ticks,
    output ready
  );
endinterface

### rtl/core/ptt_rsp_if.sv
// Result channel of the periodic timer table: valid/ready plus result fields.
// No dependencies.
interface ptt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic [3:0]  task_res;
  logic [31:0] left_ticks;
  logic        running;
  logic        last;

  modport source (
    output valid, kind, slot, task_res, left_ticks, running, last,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, task_res, left_ticks, running, last,
    output ready
  );
endinterface

### rtl/core/ptt_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module ptt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ptt_ctrl.sv
// Controller of the periodic timer table: command sequencer state machine.
// Depends on ptt_pkg; drives ptt_datapath through ctl_cmd_t / dp_status_t.
module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dp_status_t status_i,
  output ctl_cmd_t   ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    req_ready_o    = 1'b0;
    ctl_o          = '0;
    ctl_o.op       = DP_NONE;
    ctl_o.emit_sel = EM_REJECT;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctl_o.latch   = 1'b1;
          ctl_o.idx_clr = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl_o.addr_tid = 1'b1;
        unique case (status_i.cmd)
          CMD_ALLOC:   state_d = status_i.task_ok ? S_ALLOC : S_REJECT;
          CMD_FREE, CMD_STOP: begin
            if (status_i.tid_ok) begin
              ctl_o.op = DP_CLEAR;
              state_d  = S_DONE_TID;
            end else begin
              state_d = S_REJECT;
            end
          end
          CMD_START:   state_d = status_i.tid_in_use ? S_MUL : S_REJECT;
          CMD_TICK: begin
            if (status_i.now_eq_prev) begin
              state_d = S_CLOSE;
            end else begin
              ctl_o.op = DP_TICK_BEGIN;
              state_d  = S_TICK_RD;
            end
          end
          CMD_SERVICE: state_d = status_i.task_ok ? S_SRV_RD : S_REJECT;
          CMD_QUERY:   state_d = status_i.tid_ok ? S_QRY_RD : S_REJECT;
          default:     state_d = S_REJECT;
        endcase
      end
      S_ALLOC: begin
        priority if (status_i.idx_end_timer) begin
          state_d = S_REJECT;
        end else if (status_i.free_at_idx) begin
          ctl_o.op = DP_ALLOC;
          state_d  = S_DONE_IDX;
        end else begin
          ctl_o.idx_inc = 1'b1;
        end
      end
      S_MUL: begin
        ctl_o.addr_tid = 1'b1;
        ctl_o.op       = DP_MUL;
        state_d        = S_START;
      end
      S_START: begin
        ctl_o.addr_tid = 1'b1;
        ctl_o.op       = DP_START;
        state_d        = S_DONE_TID;
      end
      S_TICK_RD: begin
        state_d = S_TICK_UPD;
      end
      S_TICK_UPD: begin
        ctl_o.op = DP_TICK_UPD;
        if (status_i.idx_last_timer) begin
          ctl_o.idx_clr = 1'b1;
          state_d       = S_WAKE;
        end else begin
          ctl_o.idx_inc = 1'b1;
          state_d       = S_TICK_RD;
        end
      end
      S_WAKE: begin
        priority if (status_i.idx_end_task) begin
          state_d = S_CLOSE;
        end else if (status_i.pending_at_idx && !status_i.n_full) begin
          if (status_i.out_free) begin
            ctl_o.emit     = 1'b1;
            ctl_o.emit_sel = EM_WAKE;
            ctl_o.n_inc    = 1'b1;
            ctl_o.idx_inc  = 1'b1;
          end
        end else begin
          ctl_o.idx_inc = 1'b1;
        end
      end
      S_SRV_RD: begin
        state_d = S_SRV_CHK;
      end
      S_SRV_CHK: begin
        if (!(status_i.srv_match && !status_i.n_full && !status_i.out_free)) begin
          if (status_i.srv_match) begin
            ctl_o.op = DP_SRV_CLR;
            if (!status_i.n_full) begin
              ctl_o.emit     = 1'b1;
              ctl_o.emit_sel = EM_DUE;
              ctl_o.n_inc    = 1'b1;
            end
          end
          if (status_i.idx_last_timer) begin
            state_d = S_CLOSE;
          end else begin
            ctl_o.idx_inc = 1'b1;
            state_d       = S_SRV_RD;
          end
        end
      end
      S_QRY_RD: begin
        ctl_o.addr_tid = 1'b1;
        state_d        = S_QRY_EMIT;
      end
      S_QRY_EMIT: begin
        ctl_o.addr_tid = 1'b1;
        if (status_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.emit_sel = EM_QUERY;
          state_d        = S_IDLE;
        end
      end
      S_DONE_TID: begin
        ctl_o.addr_tid = 1'b1;
        if (status_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.emit_sel = EM_DONE_TID;
          state_d        = S_IDLE;
        end
      end
      S_DONE_IDX: begin
        if (status_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.emit_sel = EM_DONE_IDX;
          state_d        = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (status_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.emit_sel = EM_CLOSE;
          state_d        = S_IDLE;
        end
      end
      S_REJECT: begin
        if (status_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.emit_sel = EM_REJECT;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/core/ptt_datapath.sv
// Datapath of the periodic timer table: request latch, slot flags, timer RAMs,
// multiplier, countdown and the result register. Depends on ptt_pkg, ptt_ram.
module ptt_datapath
  import ptt_pkg::*;
#(
  parameter int unsigned TIMERS = 16,
  parameter int unsigned TASKS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_cmd_t    ctl_i,
  output dp_status_t  status_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  timer_id_i,
  input  logic [7:0]  task_id_i,
  input  logic [31:0] unit_i,
  input  logic [31:0] duration_i,
  input  logic [31:0] now_ticks_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [2:0]  kind_o,
  output logic [3:0]  slot_o,
  output logic [3:0]  task_res_o,
  output logic [31:0] left_ticks_o,
  output logic        running_o,
  output logic        last_o
);

  localparam int unsigned MAXN = (TIMERS > TASKS) ? TIMERS : TASKS;
  localparam int unsigned IW   = $clog2(MAXN + 1);
  localparam int unsigned AW   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned TW   = (TASKS > 1) ? $clog2(TASKS) : 1;

  logic [2:0]        cmd_q;
  logic [7:0]        tid_q;
  logic [7:0]        task_q;
  logic [31:0]       unit_q;
  logic [31:0]       dur_q;
  logic [31:0]       now_q;
  logic [31:0]       prod_q, prod_d;
  logic [31:0]       elapsed_q, elapsed_d;
  logic [31:0]       prev_q, prev_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [BODY_W-1:0] n_q, n_d;
  logic [TIMERS-1:0] in_use_q, in_use_d;
  logic [TIMERS-1:0] per_nz_q, per_nz_d;
  logic [TIMERS-1:0] due_q, due_d;
  logic [TASKS-1:0]  pending_q, pending_d;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        kind_q, kind_d;
  logic [3:0]        slot_q, slot_d;
  logic [3:0]        task_res_q, task_res_d;
  logic [31:0]       left_q, left_d;
  logic              running_q, running_d;
  logic              last_q, last_d;

  logic [AW-1:0]     addr;
  logic [3:0]        owner_rd;
  logic [31:0]       period_rd;
  logic [31:0]       rem_rd;
  logic              owner_we, period_we, rem_we;
  logic [31:0]       rem_wdata;
  logic              slot_active;
  logic              tick_hit;
  logic [31:0]       rem_sub;
  logic              out_free;

  assign addr        = ctl_i.addr_tid ? tid_q[AW-1:0] : idx_q[AW-1:0];
  assign slot_active = in_use_q[addr] && per_nz_q[addr];
  assign rem_sub     = rem_rd - elapsed_q;
  assign tick_hit    = slot_active && (rem_rd <= elapsed_q);
  assign out_free    = !out_valid_q || out_ready_i;

  assign owner_we  = (ctl_i.op == DP_ALLOC);
  assign period_we = (ctl_i.op == DP_START);
  assign rem_we    = (ctl_i.op == DP_START) || ((ctl_i.op == DP_TICK_UPD) && slot_active);
  assign rem_wdata = (ctl_i.op == DP_START) ? prod_q : (tick_hit ? period_rd : rem_sub);

  ptt_ram #(.WIDTH(4), .DEPTH(TIMERS)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (owner_we),
    .addr_i  (addr),
    .wdata_i (task_q[3:0]),
    .rdata_o (owner_rd)
  );

  ptt_ram #(.WIDTH(32), .DEPTH(TIMERS)) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (period_we),
    .addr_i  (addr),
    .wdata_i (prod_q),
    .rdata_o (period_rd)
  );

  ptt_ram #(.WIDTH(32), .DEPTH(TIMERS)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .addr_i  (addr),
    .wdata_i (rem_wdata),
    .rdata_o (rem_rd)
  );

  always_comb begin
    status_o.cmd            = cmd_q;
    status_o.tid_ok         = tid_q < 8'(TIMERS);
    status_o.task_ok        = task_q < 8'(TASKS);
    status_o.tid_in_use     = status_o.tid_ok && in_use_q[addr];
    status_o.now_eq_prev    = (now_q == prev_q);
    status_o.idx_end_timer  = (idx_q == IW'(TIMERS));
    status_o.idx_last_timer = (idx_q == IW'(TIMERS - 1));
    status_o.idx_end_task   = (idx_q == IW'(TASKS));
    status_o.free_at_idx    = !in_use_q[addr];
    status_o.srv_match      = in_use_q[addr] && due_q[addr] && ({4'd0, owner_rd} == task_q);
    status_o.pending_at_idx = pending_q[idx_q[TW-1:0]];
    status_o.n_full         = (n_q == BODY_W'(MAX_BODY));
    status_o.out_free       = out_free;
  end

  always_comb begin
    idx_d     = idx_q;
    n_d       = n_q;
    prod_d    = prod_q;
    elapsed_d = elapsed_q;
    prev_d    = prev_q;
    in_use_d  = in_use_q;
    per_nz_d  = per_nz_q;
    due_d     = due_q;
    pending_d = pending_q;

    if (ctl_i.idx_clr) begin
      idx_d = '0;
    end else if (ctl_i.idx_inc) begin
      idx_d = idx_q + IW'(1);
    end
    if (ctl_i.latch) begin
      n_d = '0;
    end else if (ctl_i.n_inc) begin
      n_d = n_q + BODY_W'(1);
    end

    unique case (ctl_i.op)
      DP_NONE: ;
      DP_ALLOC: begin
        in_use_d[addr] = 1'b1;
        per_nz_d[addr] = 1'b0;
        due_d[addr]    = 1'b0;
      end
      DP_CLEAR: begin
        per_nz_d[addr] = 1'b0;
        due_d[addr]    = 1'b0;
        if (cmd_q == CMD_FREE) begin
          in_use_d[addr] = 1'b0;
        end
      end
      DP_MUL: begin
        prod_d = 32'(unit_q * dur_q);
      end
      DP_START: begin
        per_nz_d[addr] = (prod_q != 32'd0);
        due_d[addr]    = 1'b0;
      end
      DP_TICK_BEGIN: begin
        elapsed_d = now_q - prev_q;
        prev_d    = now_q;
        pending_d = '0;
      end
      DP_TICK_UPD: begin
        if (tick_hit) begin
          due_d[addr] = 1'b1;
          for (int k = 0; k < TASKS; k++) begin
            if (8'(owner_rd) == 8'(k)) begin
              pending_d[k] = 1'b1;
            end
          end
        end
      end
      DP_SRV_CLR: begin
        due_d[addr] = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    slot_d      = slot_q;
    task_res_d  = task_res_q;
    left_d      = left_q;
    running_d   = running_q;
    last_d      = last_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl_i.emit) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_DONE;
      slot_d      = 4'd0;
      task_res_d  = 4'd0;
      left_d      = 32'd0;
      running_d   = 1'b0;
      last_d      = 1'b1;
      unique case (ctl_i.emit_sel)
        EM_REJECT:   kind_d = KIND_REJECT;
        EM_DONE_TID: slot_d = tid_q[3:0];
        EM_DONE_IDX: slot_d = 4'(idx_q);
        EM_CLOSE:    ;
        EM_WAKE: begin
          kind_d     = KIND_WAKE;
          task_res_d = 4'(idx_q);
          last_d     = 1'b0;
        end
        EM_DUE: begin
          kind_d = KIND_DUE;
          slot_d = 4'(idx_q);
          last_d = 1'b0;
        end
        EM_QUERY: begin
          kind_d    = KIND_QUERY;
          slot_d    = tid_q[3:0];
          running_d = slot_active;
          left_d    = slot_active ? rem_rd : 32'd0;
        end
        default: kind_d = KIND_REJECT;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q  <= command_i;
      tid_q  <= timer_id_i;
      task_q <= task_id_i;
      unit_q <= unit_i;
      dur_q  <= duration_i;
      now_q  <= now_ticks_i;
    end
    prod_q     <= prod_d;
    elapsed_q  <= elapsed_d;
    kind_q     <= kind_d;
    slot_q     <= slot_d;
    task_res_q <= task_res_d;
    left_q     <= left_d;
    running_q  <= running_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      n_q         <= '0;
      prev_q      <= 32'd0;
      in_use_q    <= '0;
      per_nz_q    <= '0;
      due_q       <= '0;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      n_q         <= n_d;
      prev_q      <= prev_d;
      in_use_q    <= in_use_d;
      per_nz_q    <= per_nz_d;
      due_q       <= due_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign slot_o       = slot_q;
  assign task_res_o   = task_res_q;
  assign left_ticks_o = left_q;
  assign running_o    = running_q;
  assign last_o       = last_q;

endmodule

### rtl/core/periodic_timer_table.sv
// Periodic timer table top level: joins the controller and the datapath.
// Depends on ptt_pkg, ptt_req_if, ptt_rsp_if, ptt_ctrl, ptt_datapath.
//
// req_i carries one command per request (allocate, free, start, stop, tick,
// service, query); rsp_o returns its result items, the final one with last
// set. One request is worked on at a time; the next is taken in the cycle
// after the closing item enters the output register, even if it waits there.
// Steps per request:
//   free, stop, rejects, tick with no elapsed time: decode, then the result;
//   query: decode, a read of the remaining-count RAM, then the result;
//   start: decode, one multiply stage, the RAM writes, then the result;
//   allocate: a walk to the first free slot, or over all slots when full;
//   service: a read and a check per slot, as the one-port owner RAM is
//   read per slot; tick: a read/update pass over the remaining-count RAM
//   and then the walk over task flags.
// Reset clears all slot flags, task flags and the previous tick count; the
// RAMs need no clearing pass, since a slot's entries are read only after it
// was allocated or started. A stalled rsp_o holds the current item and
// pauses the walk; no item is lost or repeated.
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int unsigned TIMERS = 16,
  parameter int unsigned TASKS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ptt_req_if.sink   req_i,
  ptt_rsp_if.source rsp_o
);

  ctl_cmd_t   ctl;
  dp_status_t status;

  ptt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .ctl_o       (ctl)
  );

  ptt_datapath #(
    .TIMERS (TIMERS),
    .TASKS  (TASKS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .status_o     (status),
    .command_i    (req_i.command),
    .timer_id_i   (req_i.timer_id),
    .task_id_i    (req_i.task_id),
    .unit_i       (req_i.unit),
    .duration_i   (req_i.duration),
    .now_ticks_i  (req_i.now_ticks),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .kind_o       (rsp_o.kind),
    .slot_o       (rsp_o.slot),
    .task_res_o   (rsp_o.task_res),
    .left_ticks_o (rsp_o.left_ticks),
    .running_o    (rsp_o.running),
    .last_o       (rsp_o.last)
  );

endmodule
